FILE: rtl/qdra_pkg.sv
// Package with shared constants, codes and command/status types of the rate averager.
package qdra_pkg;

    localparam int MaxBins = 8;
    localparam int BinW = $clog2(MaxBins);

    // Request codes.
    localparam logic [1:0] ReqEdgeA = 2'd0;
    localparam logic [1:0] ReqEdgeB = 2'd1;
    localparam logic [1:0] ReqSetPos = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CfgClocksPerUs = 3'd0;
    localparam logic [2:0] CfgMinTick = 3'd1;
    localparam logic [2:0] CfgShortSamples = 3'd2;
    localparam logic [2:0] CfgLongSamples = 3'd3;
    localparam logic [2:0] CfgBinCount = 3'd4;
    localparam logic [2:0] CfgBinMin = 3'd5;
    localparam logic [2:0] CfgBinMax = 3'd6;

    // Divider operand select.
    typedef enum logic [2:0] {
        DIV_BIN, DIV_TUS, DIV_SINGLE_US, DIV_SHORT, DIV_LONG
    } t_div_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    edge_upd;
        logic    div_start;
        t_div_op div_op;
        logic    div_store;
        logic    bin_stamp;
        logic    avg_write;
        logic    finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_edge;
        logic slow;
        logic binned;
        logic in_window;
        logic div_done;
    } t_status;

endpackage

FILE: rtl/qdra_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface qdra_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/qdra_divider.sv
// Radix-2 restoring divider for a 64-bit dividend by a 32-bit divisor.
module qdra_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient,
    output logic [31:0] o_remainder
);
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;
    logic [33:0] n_diff;

    // One quotient bit per cycle while busy; the remainder stays below the divisor.
    always_comb begin
        n_shift = {r_rem, r_quo[63]};
        n_diff = {1'b0, n_shift} - {2'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'd0;
                r_quo <= i_dividend;
                r_rem <= '0;
            end else if (r_busy) begin
                if (!n_diff[33]) begin
                    r_rem <= n_diff[31:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift[31:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_quo;
    assign o_remainder = r_rem;
endmodule

FILE: rtl/qdra_datapath.sv
// Datapath: configuration, position, timing, bin store and averaging arithmetic.
module qdra_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic [1:0]       i_req_type,
    input  logic             i_pin_level,
    input  logic [31:0]      i_clock_count,
    input  logic [31:0]      i_new_position,
    input  qdra_pkg::t_cmd   i_cmd,
    output qdra_pkg::t_status o_status,
    output logic [31:0]      o_position,
    output logic [31:0]      o_elapsed_clocks,
    output logic             o_fast_motion,
    output logic             o_rate_logged,
    output logic [2:0]       o_bin_index,
    output logic [31:0]      o_short_avg_us,
    output logic [31:0]      o_long_avg_us
);
    localparam int BinW = qdra_pkg::BinW;

    logic [9:0]  r_cpu;
    logic [31:0] r_min_tick, r_bin_min, r_bin_max;
    logic [15:0] r_short_n, r_long_n;
    logic [3:0]  r_bin_cnt;

    logic [1:0]  r_req;
    logic        r_lvl;
    logic [31:0] r_clk, r_newpos;
    logic [31:0] r_count, r_last_clk, r_elapsed;
    logic        r_la, r_lb;
    logic [31:0] r_single_s, r_single_l;
    logic [31:0] r_bin_last [qdra_pkg::MaxBins];
    logic [31:0] r_bin_s [qdra_pkg::MaxBins];
    logic [31:0] r_bin_l [qdra_pkg::MaxBins];
    logic [BinW-1:0] r_bidx;
    logic [31:0] r_tus, r_sample, r_new_s, r_new_l;
    logic        r_binrun, r_logged;

    logic [31:0] n_cpu, n_nb, n_mag, n_wshort, n_wlong, n_div_vis;
    logic [63:0] n_dividend;
    logic [31:0] n_divisor;
    logic [63:0] w_quo;
    logic [31:0] w_rem;
    logic        w_done;
    logic        n_down;
    logic [31:0] n_count;

    // Effective constants with zero treated as one, bins saturated, and the position magnitude.
    always_comb begin
        n_cpu = (r_cpu == 10'd0) ? 32'd1 : {22'd0, r_cpu};
        n_nb = (r_bin_cnt > 4'(qdra_pkg::MaxBins)) ? 32'(qdra_pkg::MaxBins)
                                                   : {28'd0, r_bin_cnt};
        n_wshort = (r_short_n == 16'd0) ? 32'd1 : {16'd0, r_short_n};
        n_wlong = (r_long_n == 16'd0) ? 32'd1 : {16'd0, r_long_n};
        n_mag = r_count[31] ? (32'd0 - r_count) : r_count;
    end

    // Quadrature step from the latched item.
    always_comb begin
        if (r_req == qdra_pkg::ReqEdgeA) begin
            n_down = (r_lvl != r_lb);
        end else begin
            n_down = (r_la == r_lvl);
        end
        n_count = n_down ? r_count - 32'd1 : r_count + 32'd1;
    end

    // Divider operand selection; averages use 48-bit products.
    always_comb begin
        n_dividend = '0;
        n_divisor = n_cpu;
        case (i_cmd.div_op)
            qdra_pkg::DIV_BIN: begin
                n_dividend = {32'd0, n_mag};
                n_divisor = n_nb;
            end
            qdra_pkg::DIV_TUS: n_dividend = {32'd0, r_clk};
            qdra_pkg::DIV_SINGLE_US: n_dividend = {32'd0, r_elapsed};
            qdra_pkg::DIV_SHORT: begin
                n_dividend = {32'd0, (r_binrun ? r_bin_s[r_bidx] : r_single_s)}
                             * {48'd0, n_wshort[15:0] - 16'd1} + {32'd0, r_sample};
                n_divisor = n_wshort;
            end
            qdra_pkg::DIV_LONG: begin
                n_dividend = {32'd0, (r_binrun ? r_bin_l[r_bidx] : r_single_l)}
                             * {48'd0, n_wlong[15:0] - 16'd1} + {32'd0, r_sample};
                n_divisor = n_wlong;
            end
            default: ;
        endcase
    end

    qdra_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(n_dividend), .i_divisor(n_divisor),
        .o_done(w_done), .o_quotient(w_quo), .o_remainder(w_rem)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu <= 10'd100;
            r_min_tick <= 32'd1000;
            r_short_n <= 16'd20;
            r_long_n <= 16'd200;
            r_bin_cnt <= 4'd0;
            r_bin_min <= 32'd0;
            r_bin_max <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qdra_pkg::CfgClocksPerUs: r_cpu <= i_cfg_data[9:0];
                qdra_pkg::CfgMinTick: r_min_tick <= i_cfg_data;
                qdra_pkg::CfgShortSamples: r_short_n <= i_cfg_data[15:0];
                qdra_pkg::CfgLongSamples: r_long_n <= i_cfg_data[15:0];
                qdra_pkg::CfgBinCount: r_bin_cnt <= i_cfg_data[3:0];
                qdra_pkg::CfgBinMin: r_bin_min <= i_cfg_data;
                qdra_pkg::CfgBinMax: r_bin_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_div_vis = w_quo[31:0];

    // Block state updated on controller commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_la <= 1'b0;
            r_lb <= 1'b0;
            r_last_clk <= '0;
            r_elapsed <= '0;
            r_single_s <= '0;
            r_single_l <= '0;
            r_binrun <= 1'b0;
            r_logged <= 1'b0;
            r_bidx <= '0;
            r_req <= '0;
            for (int i = 0; i < qdra_pkg::MaxBins; i++) begin
                r_bin_last[i] <= '0;
                r_bin_s[i] <= '0;
                r_bin_l[i] <= '0;
            end
        end else begin
            if (i_cmd.capture) begin
                r_req <= i_req_type;
                r_lvl <= i_pin_level;
                r_clk <= i_clock_count;
                r_newpos <= i_new_position;
                r_binrun <= 1'b0;
                r_logged <= 1'b0;
                r_bidx <= '0;
            end
            if (i_cmd.edge_upd) begin
                if (r_req == qdra_pkg::ReqEdgeA || r_req == qdra_pkg::ReqEdgeB) begin
                    if (r_req == qdra_pkg::ReqEdgeA) r_la <= r_lvl;
                    else r_lb <= r_lvl;
                    r_count <= n_count;
                    r_elapsed <= r_clk - r_last_clk;
                    r_last_clk <= r_clk;
                end else begin
                    r_elapsed <= '0;
                    if (r_req == qdra_pkg::ReqSetPos) r_count <= r_newpos;
                end
            end
            if (i_cmd.div_store) begin
                case (i_cmd.div_op)
                    qdra_pkg::DIV_BIN: begin
                        r_bidx <= w_rem[BinW-1:0];
                        r_binrun <= 1'b1;
                    end
                    qdra_pkg::DIV_TUS: r_tus <= n_div_vis;
                    qdra_pkg::DIV_SINGLE_US: r_sample <= n_div_vis;
                    qdra_pkg::DIV_SHORT: r_new_s <= n_div_vis;
                    qdra_pkg::DIV_LONG: r_new_l <= n_div_vis;
                    default: ;
                endcase
            end
            if (i_cmd.bin_stamp) begin
                r_sample <= r_tus - r_bin_last[r_bidx];
                r_bin_last[r_bidx] <= r_tus;
            end
            if (i_cmd.avg_write) begin
                r_logged <= 1'b1;
                if (r_binrun) begin
                    r_bin_s[r_bidx] <= r_new_s;
                    r_bin_l[r_bidx] <= r_new_l;
                end else begin
                    r_single_s <= r_new_s;
                    r_single_l <= r_new_l;
                end
            end
        end
    end

    // Result registers loaded at the end of an item; only edges can be fast.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_position <= r_count;
            o_elapsed_clocks <= r_elapsed;
            o_fast_motion <= o_status.is_edge && (r_elapsed < r_min_tick);
            o_rate_logged <= r_logged;
            o_bin_index <= 3'(r_bidx);
            if (n_nb != 32'd0) begin
                o_short_avg_us <= r_bin_s[r_bidx];
                o_long_avg_us <= r_bin_l[r_bidx];
            end else begin
                o_short_avg_us <= r_single_s;
                o_long_avg_us <= r_single_l;
            end
        end
    end

    assign o_status.is_edge = (r_req == qdra_pkg::ReqEdgeA) || (r_req == qdra_pkg::ReqEdgeB);
    assign o_status.slow = r_elapsed > r_min_tick;
    assign o_status.binned = n_nb != 32'd0;
    assign o_status.in_window = (r_sample > r_bin_min) && (r_sample < r_bin_max);
    assign o_status.div_done = w_done;
endmodule

FILE: rtl/qdra_controller.sv
// Controller state machine sequencing one transaction through the datapath.
module qdra_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  qdra_pkg::t_status i_status,
    output qdra_pkg::t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_CHECK, S_DIV_BIN, S_DIV_TUS, S_STAMP, S_WIN,
        S_DIV_US, S_DIV_SHORT, S_DIV_LONG, S_WRITE, S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_wait;
    logic   w_accept;
    logic   w_out_free;

    // The result register frees when it is empty or being taken this cycle.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Command decode per state.
    always_comb begin
        o_cmd = '0;
        o_cmd.div_op = qdra_pkg::DIV_BIN;
        o_cmd.capture = w_accept;
        case (r_state)
            S_EDGE: o_cmd.edge_upd = 1'b1;
            S_DIV_BIN: o_cmd.div_op = qdra_pkg::DIV_BIN;
            S_DIV_TUS: o_cmd.div_op = qdra_pkg::DIV_TUS;
            S_DIV_US: o_cmd.div_op = qdra_pkg::DIV_SINGLE_US;
            S_DIV_SHORT: o_cmd.div_op = qdra_pkg::DIV_SHORT;
            S_DIV_LONG: o_cmd.div_op = qdra_pkg::DIV_LONG;
            S_STAMP: o_cmd.bin_stamp = 1'b1;
            S_WRITE: o_cmd.avg_write = 1'b1;
            S_FINISH: o_cmd.finish = w_out_free;
            default: ;
        endcase
        if (r_state inside {S_DIV_BIN, S_DIV_TUS, S_DIV_US, S_DIV_SHORT, S_DIV_LONG}) begin
            o_cmd.div_start = !r_wait;
            o_cmd.div_store = i_status.div_done;
        end
    end

    // State and registered handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            if (o_cmd.div_start) r_wait <= 1'b1;
            if (i_status.div_done) r_wait <= 1'b0;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_accept) r_state <= S_EDGE;
                S_EDGE: r_state <= S_CHECK;
                S_CHECK: begin
                    if (!i_status.is_edge || !i_status.slow) r_state <= S_FINISH;
                    else if (i_status.binned) r_state <= S_DIV_BIN;
                    else r_state <= S_DIV_US;
                end
                S_DIV_BIN: if (i_status.div_done) r_state <= S_DIV_TUS;
                S_DIV_TUS: if (i_status.div_done) r_state <= S_STAMP;
                S_STAMP: r_state <= S_WIN;
                S_WIN: r_state <= i_status.in_window ? S_DIV_SHORT : S_FINISH;
                S_DIV_US: if (i_status.div_done) r_state <= S_DIV_SHORT;
                S_DIV_SHORT: if (i_status.div_done) r_state <= S_DIV_LONG;
                S_DIV_LONG: if (i_status.div_done) r_state <= S_WRITE;
                S_WRITE: r_state <= S_FINISH;
                S_FINISH: begin
                    // Hold the finished item until the result register frees.
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/quadrature_decoder_rate_averager.sv
// Set positions, idle codes and edges that are not slow skip the divider; slow edges
// run three divisions unbinned, or two binned and two more if in the bin window.
// Transactions go one at a time; the 64-step divider is shared by all divisions.
// A waiting result does not block the next input transaction.
// Reset (synchronous, active low) loads defaults, clears decoder and average state.
// Top level: quadrature decoder with edge-interval rate averaging.
module quadrature_decoder_rate_averager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    qdra_stream_if.sink   in_if,
    qdra_stream_if.source out_if
);
    qdra_pkg::t_cmd    w_cmd;
    qdra_pkg::t_status w_status;

    qdra_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_if.valid), .o_in_ready(in_if.ready),
        .o_out_valid(out_if.valid), .i_out_ready(out_if.ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    qdra_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_type(in_if.data.req_type), .i_pin_level(in_if.data.pin_level),
        .i_clock_count(in_if.data.clock_count), .i_new_position(in_if.data.new_position),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_position(out_if.data.position), .o_elapsed_clocks(out_if.data.elapsed_clocks),
        .o_fast_motion(out_if.data.fast_motion), .o_rate_logged(out_if.data.rate_logged),
        .o_bin_index(out_if.data.bin_index), .o_short_avg_us(out_if.data.short_avg_us),
        .o_long_avg_us(out_if.data.long_avg_us)
    );
endmodule

FILE: bench/qdra_tb_pkg.sv
// Transaction types shared by the rate averager testbench files.
package qdra_tb_pkg;

    // Request code that the block ignores.
    localparam logic [1:0] ReqIgnored = 2'd3;

    // One request transaction.
    typedef struct packed {
        logic [1:0]  req_type;
        logic        pin_level;
        logic [31:0] clock_count;
        logic [31:0] new_position;
    } t_edge_req;

    // One result transaction.
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] elapsed_clocks;
        logic        fast_motion;
        logic        rate_logged;
        logic [2:0]  bin_index;
        logic [31:0] short_avg_us;
        logic [31:0] long_avg_us;
    } t_edge_res;

endpackage

FILE: bench/qdra_checker.sv
// Checker that predicts each result of the rate averager and compares it.
module qdra_checker
    import qdra_pkg::*;
    import qdra_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_edge_req   i_req,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  t_edge_res   i_res,
    output int          o_pending,
    output int          o_errors
);

    // Register copies.
    logic [9:0]  cpu_reg;
    logic [31:0] min_tick_reg;
    logic [15:0] short_n_reg;
    logic [15:0] long_n_reg;
    logic [3:0]  bins_reg;
    logic [31:0] win_lo_reg;
    logic [31:0] win_hi_reg;

    // Decoder and averaging state.
    logic [31:0] pos_cnt;
    logic        lev_a;
    logic        lev_b;
    logic [31:0] last_stamp;
    logic [31:0] one_short;
    logic [31:0] one_long;
    logic [31:0] bin_stamp_us [MaxBins];
    logic [31:0] bin_short [MaxBins];
    logic [31:0] bin_long [MaxBins];

    t_edge_res expected_results [$];

    assign o_pending = expected_results.size();

    // Running average with weight n, a zero weight acting as one.
    function automatic logic [31:0] blend(logic [31:0] old, logic [31:0] smp, logic [15:0] n);
        logic [63:0] w;
        logic [63:0] acc;
        w = (n == 0) ? 64'd1 : {48'd0, n};
        acc = {32'd0, old} * (w - 64'd1) + {32'd0, smp};
        return 32'(acc / w);
    endfunction

    // Apply one request to the state copy and return its result.
    function automatic t_edge_res decode_edge(t_edge_req rq);
        t_edge_res   r;
        logic [31:0] nb;
        logic [31:0] cpu;
        logic [31:0] mag;
        logic [31:0] idx;
        logic [31:0] t_us;
        logic [31:0] smp;
        logic        down;
        logic        bin_run;
        r = '0;
        bin_run = 1'b0;
        idx = 0;
        nb = (bins_reg > MaxBins) ? MaxBins : {28'd0, bins_reg};
        cpu = (cpu_reg == 0) ? 32'd1 : {22'd0, cpu_reg};
        if (rq.req_type == ReqEdgeA || rq.req_type == ReqEdgeB) begin
            if (rq.req_type == ReqEdgeA) begin
                lev_a = rq.pin_level;
                down = (lev_a != lev_b);
            end else begin
                lev_b = rq.pin_level;
                down = (lev_a == lev_b);
            end
            pos_cnt = down ? pos_cnt - 32'd1 : pos_cnt + 32'd1;
            r.elapsed_clocks = rq.clock_count - last_stamp;
            last_stamp = rq.clock_count;
            r.fast_motion = (r.elapsed_clocks < min_tick_reg);
            if (r.elapsed_clocks > min_tick_reg) begin
                if (nb > 0) begin
                    mag = pos_cnt[31] ? -pos_cnt : pos_cnt;
                    idx = mag % nb;
                    t_us = rq.clock_count / cpu;
                    smp = t_us - bin_stamp_us[idx];
                    bin_stamp_us[idx] = t_us;
                    if (smp > win_lo_reg && smp < win_hi_reg) begin
                        bin_short[idx] = blend(bin_short[idx], smp, short_n_reg);
                        bin_long[idx] = blend(bin_long[idx], smp, long_n_reg);
                        r.rate_logged = 1'b1;
                    end
                    bin_run = 1'b1;
                end else begin
                    smp = r.elapsed_clocks / cpu;
                    one_short = blend(one_short, smp, short_n_reg);
                    one_long = blend(one_long, smp, long_n_reg);
                    r.rate_logged = 1'b1;
                end
            end
        end else if (rq.req_type == ReqSetPos) begin
            pos_cnt = rq.new_position;
        end
        r.position = pos_cnt;
        if (bin_run || nb > 0) begin
            r.bin_index = idx[2:0];
            r.short_avg_us = bin_short[idx];
            r.long_avg_us = bin_long[idx];
        end else begin
            r.short_avg_us = one_short;
            r.long_avg_us = one_long;
        end
        return r;
    endfunction

    // Compare one field and report the early mismatches.
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            if (o_errors < 10)
                $display("mismatch %s: expected %h, actual %h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    // Track configuration, predict on each request, check each result.
    always @(posedge i_clk) begin
        t_edge_res e;
        if (!i_rst_n) begin
            cpu_reg <= 10'd100;
            min_tick_reg <= 32'd1000;
            short_n_reg <= 16'd20;
            long_n_reg <= 16'd200;
            bins_reg <= 4'd0;
            win_lo_reg <= 32'd0;
            win_hi_reg <= 32'hFFFF_FFFF;
            pos_cnt = '0;
            lev_a = 1'b0;
            lev_b = 1'b0;
            last_stamp = '0;
            one_short = '0;
            one_long = '0;
            for (int i = 0; i < MaxBins; i++) begin
                bin_stamp_us[i] = '0;
                bin_short[i] = '0;
                bin_long[i] = '0;
            end
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("mismatch: result with none expected");
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("position", e.position, i_res.position);
                    check_field("elapsed_clocks", e.elapsed_clocks, i_res.elapsed_clocks);
                    check_field("fast_motion", 32'(e.fast_motion), 32'(i_res.fast_motion));
                    check_field("rate_logged", 32'(e.rate_logged), 32'(i_res.rate_logged));
                    check_field("bin_index", 32'(e.bin_index), 32'(i_res.bin_index));
                    check_field("short_avg_us", e.short_avg_us, i_res.short_avg_us);
                    check_field("long_avg_us", e.long_avg_us, i_res.long_avg_us);
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(decode_edge(i_req));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgClocksPerUs: cpu_reg <= i_cfg_data[9:0];
                    CfgMinTick: min_tick_reg <= i_cfg_data;
                    CfgShortSamples: short_n_reg <= i_cfg_data[15:0];
                    CfgLongSamples: long_n_reg <= i_cfg_data[15:0];
                    CfgBinCount: bins_reg <= i_cfg_data[3:0];
                    CfgBinMin: win_lo_reg <= i_cfg_data;
                    CfgBinMax: win_hi_reg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial o_errors = 0;

endmodule

FILE: bench/testbench.sv
// Testbench top: stimulus, configuration phases and verdict for the rate averager.
module testbench;
    import qdra_pkg::*;
    import qdra_tb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          pending;
    int          errors;
    logic        quiet;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] stamp;
    logic [31:0] cur_min_tick;

    qdra_stream_if #(.T(t_edge_req)) req_ch ();
    qdra_stream_if #(.T(t_edge_res)) res_ch ();

    quadrature_decoder_rate_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_if       (req_ch),
        .out_if      (res_ch)
    );

    qdra_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.data),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res       (res_ch.data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Safety limit on the whole run.
    initial begin
        #50_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Result side: random stall before each transaction.
    initial begin
        int n;
        res_ch.ready = 1'b0;
        forever begin
            n = quiet ? 0 : $urandom_range(0, 5);
            if (n > 0) res_ch.ready = 1'b0;
            repeat (n) @(negedge i_clk);
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge i_clk);
        end
    end

    // Send one request transaction after a random gap.
    task automatic send_req(logic [1:0] rt, logic lvl, logic [31:0] cc, logic [31:0] np);
        int n;
        n = quiet ? 0 : $urandom_range(0, 5);
        repeat (n) @(negedge i_clk);
        req_ch.data = '{req_type: rt, pin_level: lvl, clock_count: cc, new_position: np};
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CfgMinTick) cur_min_tick = val;
    endtask

    // Let every outstanding result drain, then cover the slowest division.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Pick the next edge timestamp around the slow/fast threshold.
    task automatic advance_stamp();
        case ($urandom_range(0, 9))
            0: stamp = stamp + cur_min_tick;
            1: stamp = stamp + cur_min_tick - 32'd1;
            2: stamp = stamp + $urandom_range(0, 50);
            3: stamp = $urandom;
            default: stamp = stamp + cur_min_tick + $urandom_range(1, 200000);
        endcase
    endtask

    // Well-formed quadrature step up or down.
    task automatic step(logic down);
        advance_stamp();
        if ((pin_a == pin_b) == down) begin
            pin_a = ~pin_a;
            send_req(ReqEdgeA, pin_a, stamp, $urandom);
        end else begin
            pin_b = ~pin_b;
            send_req(ReqEdgeB, pin_b, stamp, $urandom);
        end
    endtask

    // Mostly runs of steps in one direction, with loads and noise between.
    task automatic random_items(int total);
        int sent;
        int run;
        logic dir;
        logic [1:0] rt;
        sent = 0;
        while (sent < total) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_req(ReqSetPos, $urandom, $urandom,
                        $urandom_range(0, 1) ? $urandom : 32'h8000_0000 + $urandom_range(0, 3));
                    sent++;
                end
                1: begin
                    rt = $urandom;
                    advance_stamp();
                    send_req(rt, $urandom, stamp, $urandom);
                    if (rt == ReqEdgeA) pin_a = req_ch.data.pin_level;
                    if (rt == ReqEdgeB) pin_b = req_ch.data.pin_level;
                    sent++;
                end
                default: begin
                    run = $urandom_range(1, 12);
                    dir = $urandom;
                    repeat (run) step(dir);
                    sent += run;
                end
            endcase
            if ($urandom_range(0, 40) == 0) quiet = ~quiet;
        end
    endtask

    // Write all registers of one setting.
    task automatic set_all(logic [31:0] cpu, logic [31:0] mt, logic [31:0] sn, logic [31:0] ln,
                           logic [31:0] nb, logic [31:0] lo, logic [31:0] hi);
        write_reg(CfgClocksPerUs, cpu);
        write_reg(CfgMinTick, mt);
        write_reg(CfgShortSamples, sn);
        write_reg(CfgLongSamples, ln);
        write_reg(CfgBinCount, nb);
        write_reg(CfgBinMin, lo);
        write_reg(CfgBinMax, hi);
    endtask

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        quiet = 1'b0;
        pin_a = 1'b0;
        pin_b = 1'b0;
        stamp = '0;
        cur_min_tick = 32'd1000;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: default registers.
        send_req(ReqSetPos, 1'b0, 32'd0, 32'h7FFF_FFFF);
        send_req(ReqEdgeB, 1'b1, 32'd1000, 32'd0);
        send_req(ReqEdgeA, 1'b1, 32'd1999, 32'd0);
        send_req(ReqEdgeB, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(ReqEdgeA, 1'b0, 32'd5, 32'd0);
        send_req(ReqSetPos, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000);
        send_req(ReqEdgeA, 1'b1, 32'd3000, 32'd0);
        send_req(ReqIgnored, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678);
        send_req(ReqSetPos, 1'b0, 32'd0, 32'd0);
        send_req(ReqEdgeB, 1'b1, 32'd3001, 32'd0);
        pin_a = 1'b1;
        pin_b = 1'b1;
        stamp = 32'd3001;
        drain();

        // Directed: saturated bin count, most negative position, extreme scales.
        set_all(32'd0, 32'd0, 32'd0, 32'd65535, 32'd15, 32'd0, 32'hFFFF_FFFF);
        send_req(ReqSetPos, 1'b0, 32'd0, 32'h8000_0001);
        step(1'b1);
        step(1'b1);
        send_req(ReqSetPos, 1'b0, 32'd0, 32'h8000_0000);
        step(1'b0);
        step(1'b0);
        send_req(ReqIgnored, 1'b0, 32'd0, 32'd0);
        drain();
        set_all(32'd1023, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0);
        send_req(ReqEdgeA, ~pin_a, stamp + 32'hFFFF_FFFF, 32'd0);
        send_req(ReqEdgeB, ~pin_b, stamp, 32'd0);
        pin_a = ~pin_a;
        pin_b = ~pin_b;
        drain();

        // Random phases through several settings.
        set_all(32'd1, 32'd0, 32'd1, 32'd65535, 32'd0, 32'd0, 32'hFFFF_FFFF);
        random_items(150);
        drain();
        set_all(32'd0, 32'd50, 32'd0, 32'd0, 32'd3, 32'd0, 32'hFFFF_FFFF);
        random_items(150);
        drain();
        set_all(32'd1023, 32'hFFFF_FFFF, 32'd65535, 32'd2, 32'd8, 32'd5, 32'd2000);
        random_items(100);
        drain();
        set_all(32'd100, 32'd1000, 32'd20, 32'd200, 32'd5, 32'd0, 32'd0);
        random_items(100);
        drain();
        repeat (4) begin
            set_all($urandom_range(1, 1000), $urandom_range(10, 5000), $urandom_range(1, 65535),
                    $urandom_range(1, 65535), $urandom_range(0, 15), $urandom_range(0, 50),
                    $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(100, 100000));
            random_items(130);
            drain();
        end

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: quadrature_decoder_rate_averager.f
rtl/qdra_pkg.sv
rtl/qdra_stream_if.sv
rtl/qdra_divider.sv
rtl/qdra_datapath.sv
rtl/qdra_controller.sv
rtl/quadrature_decoder_rate_averager.sv
bench/qdra_tb_pkg.sv
bench/qdra_checker.sv
bench/testbench.sv
